@@ hw/rtl/astc_pkg.sv @@
// Package: shared constants, types and codes of the scope trigger capture block.
package astc_pkg;

    localparam int CAPTURE_DEPTH = 65536;
    localparam int CAP_AW        = $clog2(CAPTURE_DEPTH);
    localparam int MAX_BLOCK     = 1024;
    localparam int TRIG_DEPTH    = 2 * MAX_BLOCK;
    localparam int TRIG_AW       = $clog2(TRIG_DEPTH);
    localparam int BLK_W         = $clog2(MAX_BLOCK) + 1;
    localparam int CNT_W         = CAP_AW + 1;

    localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
    localparam logic signed [15:0] S16_MIN = -16'sh8000;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_START  = 2'd1,
        FUNC_ABORT  = 2'd2,
        FUNC_READ   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_WAIT    = 2'd1,
        MODE_CAPTURE = 2'd2,
        MODE_ABORTED = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_LEVEL    = 3'd0,
        CFG_RISING   = 3'd1,
        CFG_ON_START = 3'd2,
        CFG_CONTIG   = 3'd3,
        CFG_CAP_LEN  = 3'd4,
        CFG_BLK_LEN  = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_READ_WAIT,
        ST_SAMPLE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_SEARCH_RD,
        ST_SEARCH_CHK,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_REPORT
    } bstate_t;

    // One classified command handed from the front part to the back part.
    typedef struct packed {
        func_t                    func;
        logic signed [15:0]       mono;
        logic [15:0]              addr;
    } cmd_t;

    typedef struct packed {
        logic                     kind;
        logic signed [15:0]       block_min;
        logic signed [15:0]       block_max;
        logic signed [15:0]       total_min;
        logic signed [15:0]       total_max;
        logic [1:0]               status;
        logic [16:0]              samples_available;
        logic [9:0]               pretrigger_position;
        logic signed [15:0]       read_data;
    } result_t;

endpackage

@@ hw/rtl/audio_scope_trigger_capture.sv @@
// Top level: scope trigger and capture block for stereo audio samples.
//
// Usage: items arrive on the s_axis stream. s_tuser carries the command
// (sample pair, start, abort, read); s_tdata carries left, right and the read
// address. A front stage averages each pair to mono and drops the command
// into a four-deep queue; a back sequencer executes commands one at a time.
// Results leave on m_axis from an output register: a block report after the
// last sample of each block, read data after a read command.
// The sequencer pops a new command only from its idle state, once the last one
// is done. At the first sample of a block in trigger wait with a full trigger
// store, it shifts the newest block to the bottom of the store; at a block end in
// trigger wait it may search the store for the trigger (after priming) and copy
// the window to the capture store, all using the single-port trigger RAM.
// The input stays open while the queue has room, so short bursts are absorbed.
// Reset clears all modes, counts and extremes; both stores are left unwritten.
// A stalled m_tready holds the result; the sequencer then waits at its next result
// and the queue fills, after which s_tready drops. Configuration must be written on
// cfg_* only while the block is idle (not enforced); cfg_ready is always high.
module audio_scope_trigger_capture (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // left_sample[15:0], right_sample[31:16], read_address[47:32]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [135:0] m_tdata,  // block_min[15:0], block_max[31:16], total_min[47:32],
                                   // total_max[63:48], status[65:64], samples_available[82:66],
                                   // pretrigger_position[92:83], read_data[108:93], zero fill
    output logic        m_tuser,   // kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    logic [6:0]  level_reg;
    logic        rising_reg, on_start_reg, contig_reg;
    logic [16:0] cap_len_reg;
    logic [10:0] blk_len_reg;
    logic        q_valid, q_pop, busy;
    astc_pkg::cmd_t    q_cmd;
    astc_pkg::result_t r;

    assign cfg_ready = 1'b1;

    // Register writes; out-of-range indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= '0;
            rising_reg   <= 1'b1;
            on_start_reg <= 1'b0;
            contig_reg   <= 1'b0;
            cap_len_reg  <= 17'd65536;
            blk_len_reg  <= 11'd512;
        end
        else if (cfg_valid)
        begin
            case (astc_pkg::cfg_idx_t'(cfg_index))
                astc_pkg::CFG_LEVEL:    level_reg    <= cfg_data[6:0];
                astc_pkg::CFG_RISING:   rising_reg   <= cfg_data[0];
                astc_pkg::CFG_ON_START: on_start_reg <= cfg_data[0];
                astc_pkg::CFG_CONTIG:   contig_reg   <= cfg_data[0];
                astc_pkg::CFG_CAP_LEN:  cap_len_reg  <= cfg_data;
                astc_pkg::CFG_BLK_LEN:  blk_len_reg  <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    astc_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

    astc_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .level_pct(level_reg), .rising(rising_reg), .on_start(on_start_reg),
        .contig(contig_reg), .cap_len_raw(cap_len_reg), .blk_len_raw(blk_len_reg),
        .busy(busy), .r_valid(m_tvalid), .r_ready(m_tready), .r_data(r));

    assign m_tuser = r.kind;
    assign m_tdata = {27'd0, r.read_data, r.pretrigger_position, r.samples_available,
                      r.status, r.total_max, r.total_min, r.block_max, r.block_min};

`ifndef SYNTHESIS
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> !busy) else $error("configuration write while busy");
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
    a_kind_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[92:0] == 93'd0)) else $error("read fields");
`endif

endmodule

@@ hw/rtl/astc_ram.sv @@
// Generic single-port RAM with registered read.
module astc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hw/rtl/astc_front.sv @@
// Front part: accept input transactions, average to mono, queue commands.
module astc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    output logic                 q_valid,
    input  logic                 q_pop,
    output astc_pkg::cmd_t       q_cmd
);

    localparam int QD = 4;

    astc_pkg::cmd_t     q_reg [QD];
    logic [1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [2:0]         cnt_reg;
    logic signed [16:0] sum;
    astc_pkg::cmd_t     cmd_in;
    logic               push;

    assign sum = 17'(signed'(s_tdata[15:0])) + 17'(signed'(s_tdata[31:16]));

    always_comb
    begin
        cmd_in.func = astc_pkg::func_t'(s_tuser);
        // Arithmetic shift gives floor of the halved sum.
        cmd_in.mono = 16'(sum >>> 1);
        cmd_in.addr = s_tdata[47:32];
    end

    assign s_tready = (cnt_reg != 3'(QD));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 3'd0);
    assign q_cmd    = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(push) - 3'(q_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(QD)) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 3'(QD)) |-> !s_tready) else $error("ready while full");
`endif

endmodule

@@ hw/rtl/astc_back.sv @@
// Back part: trigger search, capture, reporting and read-back sequencer.
module astc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  astc_pkg::cmd_t       q_cmd,
    input  logic [6:0]           level_pct,
    input  logic                 rising,
    input  logic                 on_start,
    input  logic                 contig,
    input  logic [16:0]          cap_len_raw,
    input  logic [10:0]          blk_len_raw,
    output logic                 busy,
    output logic                 r_valid,
    input  logic                 r_ready,
    output astc_pkg::result_t    r_data
);

    localparam int TAW = astc_pkg::TRIG_AW;
    localparam int CAW = astc_pkg::CAP_AW;
    localparam int CW  = astc_pkg::CNT_W;
    localparam int BW  = astc_pkg::BLK_W;

    astc_pkg::bstate_t  st_reg, st_next;
    astc_pkg::mode_t    mode_reg, mode_next;
    logic [TAW:0]       twi_reg, twi_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [CW-1:0]      avail_reg, avail_next;
    logic [BW-1:0]      bpos_reg, bpos_next;
    logic signed [15:0] bmin_reg, bmin_next, bmax_reg, bmax_next;
    logic signed [15:0] tmin_reg, tmin_next, tmax_reg, tmax_next;
    logic [9:0]         tpt_reg, tpt_next;
    logic               pstart_reg, pstart_next, pabort_reg, pabort_next;
    logic [TAW:0]       i_reg, i_next;
    logic [TAW:0]       j_reg, j_next;
    logic [TAW:0]       n_reg, n_next;
    logic signed [15:0] s0_reg, s0_next, s1_reg, s1_next;
    logic [1:0]         ph_reg, ph_next;
    logic signed [15:0] mono_reg, mono_next;
    logic [15:0]        raddr_reg, raddr_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               r_valid_reg, r_valid_next;
    astc_pkg::result_t  r_data_reg, r_data_next;

    logic [BW-1:0]      b;
    logic [CW-1:0]      clen;
    logic [TAW:0]       whole;
    logic [BW-1:0]      half;

    logic               t_we, c_we;
    logic [TAW-1:0]     t_addr;
    logic [CAW-1:0]     c_addr;
    logic [15:0]        t_wdata, c_wdata, t_rdata, c_rdata;
    logic signed [22:0] lvl_prod, thr;
    logic               hit;
    logic signed [15:0] s2;

    always_comb
    begin
        b = blk_len_raw[BW-1:0];
        if (blk_len_raw < 11'd4)
        begin
            b = BW'(4);
        end
        else if (blk_len_raw > 11'(astc_pkg::MAX_BLOCK))
        begin
            b = BW'(astc_pkg::MAX_BLOCK);
        end
        clen = cap_len_raw[CW-1:0];
        if (cap_len_raw == 17'd0)
        begin
            clen = CW'(1);
        end
        else if (cap_len_raw > 17'(astc_pkg::CAPTURE_DEPTH))
        begin
            clen = CW'(astc_pkg::CAPTURE_DEPTH);
        end
    end

    assign whole = {b, 1'b0};
    assign half  = b >> 1;

    astc_ram #(.WIDTH(16), .DEPTH(astc_pkg::TRIG_DEPTH)) u_trig (
        .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata));
    astc_ram #(.WIDTH(16), .DEPTH(astc_pkg::CAPTURE_DEPTH)) u_cap (
        .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata));

    // Level test: s0*100 against percent*32768, both fit in 23 bits signed.
    assign s2       = signed'(t_rdata);
    assign lvl_prod = 23'(s0_reg) * 23'sd100;
    assign thr      = signed'({1'b0, level_pct, 15'd0});
    assign hit = rising ? ((lvl_prod >= thr) && (s1_reg >= s0_reg) && (s2 >= s1_reg))
                        : ((lvl_prod <= -thr) && (s1_reg <= s0_reg) && (s2 <= s1_reg));

    assign busy    = (st_reg != astc_pkg::ST_IDLE) || q_valid || r_valid_reg;
    assign r_valid = r_valid_reg;
    assign r_data  = r_data_reg;

    always_comb
    begin
        st_next     = st_reg;
        mode_next   = mode_reg;
        twi_next    = twi_reg;
        fill_next   = fill_reg;
        avail_next  = avail_reg;
        bpos_next   = bpos_reg;
        bmin_next   = bmin_reg;
        bmax_next   = bmax_reg;
        tmin_next   = tmin_reg;
        tmax_next   = tmax_reg;
        tpt_next    = tpt_reg;
        pstart_next = pstart_reg;
        pabort_next = pabort_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        s0_next     = s0_reg;
        s1_next     = s1_reg;
        ph_next     = ph_reg;
        mono_next   = mono_reg;
        raddr_next  = raddr_reg;
        rd_ok_next  = rd_ok_reg;
        r_valid_next = r_valid_reg;
        r_data_next = r_data_reg;
        q_pop   = 1'b0;
        t_we    = 1'b0;
        c_we    = 1'b0;
        t_addr  = i_reg[TAW-1:0];
        c_addr  = raddr_reg[CAW-1:0];
        t_wdata = mono_reg;
        c_wdata = mono_reg;

        if (r_valid_reg && r_ready)
        begin
            r_valid_next = 1'b0;
        end

        case (st_reg)
            astc_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.func)
                        astc_pkg::FUNC_START: pstart_next = 1'b1;
                        astc_pkg::FUNC_ABORT: pabort_next = 1'b1;
                        astc_pkg::FUNC_READ:
                        begin
                            raddr_next = q_cmd.addr;
                            rd_ok_next = (CW'(q_cmd.addr) < clen);
                            st_next    = astc_pkg::ST_READ;
                        end
                        default:
                        begin
                            mono_next = q_cmd.mono;
                            st_next   = astc_pkg::ST_SAMPLE;
                            if (bpos_reg == '0)
                            begin
                                if (pabort_reg)
                                begin
                                    mode_next   = astc_pkg::MODE_ABORTED;
                                    pabort_next = 1'b0;
                                end
                                if (pstart_reg && !pabort_reg)
                                begin
                                    mode_next  = on_start ? astc_pkg::MODE_WAIT
                                                          : astc_pkg::MODE_CAPTURE;
                                    fill_next  = '0;
                                    avail_next = '0;
                                    tpt_next   = '0;
                                    twi_next   = '0;
                                    tmin_next  = astc_pkg::S16_MAX;
                                    tmax_next  = astc_pkg::S16_MIN;
                                end
                                pstart_next = 1'b0;
                                // Keep only the newest block of a full trigger store.
                                if (((pstart_reg && !pabort_reg && on_start) ||
                                     (!(pstart_reg && !pabort_reg) && !pabort_reg &&
                                      mode_reg == astc_pkg::MODE_WAIT)) &&
                                    !(pstart_reg && !pabort_reg) && twi_reg >= whole)
                                begin
                                    i_next  = twi_reg - (TAW+1)'(b);
                                    j_next  = '0;
                                    st_next = astc_pkg::ST_SHIFT_RD;
                                end
                            end
                        end
                    endcase
                end
            end

            astc_pkg::ST_READ:
            begin
                st_next = astc_pkg::ST_READ_WAIT;
            end

            astc_pkg::ST_READ_WAIT:
            begin
                if (!r_valid_next)
                begin
                    r_data_next = '0;
                    r_data_next.kind = 1'b1;
                    r_data_next.read_data = rd_ok_reg ? signed'(c_rdata) : 16'sd0;
                    r_valid_next = 1'b1;
                    st_next = astc_pkg::ST_IDLE;
                end
            end

            astc_pkg::ST_SHIFT_RD:
            begin
                t_addr  = i_reg[TAW-1:0];
                st_next = astc_pkg::ST_SHIFT_WR;
            end

            astc_pkg::ST_SHIFT_WR:
            begin
                t_we    = 1'b1;
                t_addr  = j_reg[TAW-1:0];
                t_wdata = t_rdata;
                i_next  = i_reg + 1'b1;
                j_next  = j_reg + 1'b1;
                if (j_reg + 1'b1 == (TAW+1)'(b))
                begin
                    twi_next = (TAW+1)'(b);
                    st_next  = astc_pkg::ST_SAMPLE;
                end
                else
                begin
                    st_next = astc_pkg::ST_SHIFT_RD;
                end
            end

            astc_pkg::ST_SAMPLE:
            begin
                if (mono_reg < bmin_reg) bmin_next = mono_reg;
                if (mono_reg > bmax_reg) bmax_next = mono_reg;
                if (mode_reg == astc_pkg::MODE_WAIT)
                begin
                    if (twi_reg < whole)
                    begin
                        t_we     = 1'b1;
                        t_addr   = twi_reg[TAW-1:0];
                        twi_next = twi_reg + 1'b1;
                    end
                end
                else if (mode_reg == astc_pkg::MODE_CAPTURE)
                begin
                    if (fill_reg >= clen && !contig)
                    begin
                        mode_next = astc_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        c_we   = 1'b1;
                        c_addr = (fill_reg >= clen) ? '0 : fill_reg[CAW-1:0];
                        fill_next = (fill_reg >= clen) ? CW'(1) : fill_reg + 1'b1;
                        if (fill_reg >= clen || avail_reg >= clen)
                        begin
                            avail_next = clen;
                        end
                        else
                        begin
                            avail_next = avail_reg + 1'b1;
                        end
                        if (mono_reg < tmin_reg) tmin_next = mono_reg;
                        if (mono_reg > tmax_reg) tmax_next = mono_reg;
                    end
                end
                if (bpos_reg + 1'b1 < b)
                begin
                    bpos_next = bpos_reg + 1'b1;
                    st_next   = astc_pkg::ST_IDLE;
                end
                else if (mode_reg == astc_pkg::MODE_WAIT &&
                         (twi_reg >= whole || twi_reg + 1'b1 >= whole))
                begin
                    if (level_pct <= 7'd2)
                    begin
                        tpt_next = '0;
                        i_next   = '0;
                        n_next   = (CW'(whole) > clen) ? (TAW+1)'(clen) : whole;
                        j_next   = '0;
                        st_next  = astc_pkg::ST_COPY_RD;
                    end
                    else
                    begin
                        i_next  = (TAW+1)'(half);
                        ph_next = 2'd0;
                        st_next = astc_pkg::ST_SEARCH_RD;
                    end
                end
                else
                begin
                    st_next = astc_pkg::ST_REPORT;
                end
            end

            // Walk the window three reads deep; after priming, each position reads one new sample.
            astc_pkg::ST_SEARCH_RD:
            begin
                t_addr  = i_reg[TAW-1:0] + TAW'(ph_reg);
                st_next = astc_pkg::ST_SEARCH_CHK;
            end

            astc_pkg::ST_SEARCH_CHK:
            begin
                if (ph_reg == 2'd0)
                begin
                    s0_next = signed'(t_rdata);
                    ph_next = 2'd1;
                    st_next = astc_pkg::ST_SEARCH_RD;
                end
                else if (ph_reg == 2'd1)
                begin
                    s1_next = signed'(t_rdata);
                    ph_next = 2'd2;
                    st_next = astc_pkg::ST_SEARCH_RD;
                end
                else if (hit)
                begin
                    tpt_next = 10'(half);
                    i_next   = i_reg - (TAW+1)'(half);
                    n_next   = ((CW'(whole) - CW'(i_reg - (TAW+1)'(half))) > clen)
                               ? (TAW+1)'(clen) : whole - (i_reg - (TAW+1)'(half));
                    j_next   = '0;
                    st_next  = astc_pkg::ST_COPY_RD;
                end
                else if (i_reg + 1'b1 >= (TAW+1)'(half) + (TAW+1)'(b))
                begin
                    st_next = astc_pkg::ST_REPORT;
                end
                else
                begin
                    s0_next = s1_reg;
                    s1_next = s2;
                    i_next  = i_reg + 1'b1;
                    st_next = astc_pkg::ST_SEARCH_RD;
                end
            end

            astc_pkg::ST_COPY_RD:
            begin
                if (j_reg == n_reg)
                begin
                    fill_next  = CW'(n_reg);
                    avail_next = CW'(n_reg);
                    twi_next   = '0;
                    mode_next  = astc_pkg::MODE_CAPTURE;
                    st_next    = astc_pkg::ST_REPORT;
                end
                else
                begin
                    t_addr  = i_reg[TAW-1:0];
                    st_next = astc_pkg::ST_COPY_WR;
                end
            end

            astc_pkg::ST_COPY_WR:
            begin
                c_we    = 1'b1;
                c_addr  = CAW'(j_reg);
                c_wdata = t_rdata;
                if (signed'(t_rdata) < tmin_reg) tmin_next = signed'(t_rdata);
                if (signed'(t_rdata) > tmax_reg) tmax_next = signed'(t_rdata);
                i_next  = i_reg + 1'b1;
                j_next  = j_reg + 1'b1;
                st_next = astc_pkg::ST_COPY_RD;
            end

            astc_pkg::ST_REPORT:
            begin
                if (!r_valid_next)
                begin
                    r_data_next.kind                = 1'b0;
                    r_data_next.block_min           = bmin_reg;
                    r_data_next.block_max           = bmax_reg;
                    r_data_next.total_min           = tmin_reg;
                    r_data_next.total_max           = tmax_reg;
                    r_data_next.status              = mode_reg;
                    r_data_next.samples_available   = 17'(avail_reg);
                    r_data_next.pretrigger_position = tpt_reg;
                    r_data_next.read_data           = '0;
                    r_valid_next = 1'b1;
                    bpos_next = '0;
                    bmin_next = astc_pkg::S16_MAX;
                    bmax_next = astc_pkg::S16_MIN;
                    st_next   = astc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                st_next = astc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        n_reg      <= n_next;
        s0_reg     <= s0_next;
        s1_reg     <= s1_next;
        mono_reg   <= mono_next;
        raddr_reg  <= raddr_next;
        rd_ok_reg  <= rd_ok_next;
        r_data_reg <= r_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= astc_pkg::ST_IDLE;
            mode_reg    <= astc_pkg::MODE_IDLE;
            twi_reg     <= '0;
            fill_reg    <= '0;
            avail_reg   <= '0;
            bpos_reg    <= '0;
            bmin_reg    <= astc_pkg::S16_MAX;
            bmax_reg    <= astc_pkg::S16_MIN;
            tmin_reg    <= astc_pkg::S16_MAX;
            tmax_reg    <= astc_pkg::S16_MIN;
            tpt_reg     <= '0;
            pstart_reg  <= 1'b0;
            pabort_reg  <= 1'b0;
            ph_reg      <= '0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            mode_reg    <= mode_next;
            twi_reg     <= twi_next;
            fill_reg    <= fill_next;
            avail_reg   <= avail_next;
            bpos_reg    <= bpos_next;
            bmin_reg    <= bmin_next;
            bmax_reg    <= bmax_next;
            tmin_reg    <= tmin_next;
            tmax_reg    <= tmax_next;
            tpt_reg     <= tpt_next;
            pstart_reg  <= pstart_next;
            pabort_reg  <= pabort_next;
            ph_reg      <= ph_next;
            r_valid_reg <= r_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_avail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        avail_reg <= CW'(astc_pkg::CAPTURE_DEPTH)) else $error("available count overflow");
    a_twi_bound: assert property (@(posedge clk) disable iff (!rst_n)
        twi_reg <= (TAW+1)'(astc_pkg::TRIG_DEPTH)) else $error("trigger index overflow");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (st_reg == astc_pkg::ST_IDLE)) else $error("pop outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid_reg && !r_ready) |=> $stable(r_data_reg)) else $error("result changed");
`endif

endmodule

@@ verif/tb_audio_scope_trigger_capture.sv @@
// Testbench for audio_scope_trigger_capture: directed table plus random phases against a predictor.
`timescale 1ns / 100ps

module tb_audio_scope_trigger_capture;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;    // left_sample[15:0], right_sample[31:16], read_address[47:32]
    logic [1:0]   s_tuser;    // func[1:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;    // block_min, block_max, total_min, total_max, status,
                              // samples_available, pretrigger_position, read_data
    logic         m_tuser;    // kind
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [16:0]  cfg_data;

    audio_scope_trigger_capture DUT (.*);

    // Predictor state: a shadow of the block's stores, counters and registers.
    logic signed [15:0] trig_mem [astc_pkg::TRIG_DEPTH];
    logic signed [15:0] cap_mem  [astc_pkg::CAPTURE_DEPTH];
    bit                 cap_seen [astc_pkg::CAPTURE_DEPTH];
    int unsigned        trig_wr, cap_fill, avail_cnt, blk_pos, trig_pt;
    int                 blk_lo, blk_hi, tot_lo, tot_hi;
    astc_pkg::mode_t    mode;
    bit                 start_pend, abort_pend;
    int unsigned        lvl_pct, rising, arm_on_start, wrap_mode, cap_len_reg, blk_len_reg;

    astc_pkg::result_t pending_results[$];
    int          errors;
    bit          quiet;

    function automatic int unsigned eff_blk();
        return (blk_len_reg < 4) ? 4 :
               (blk_len_reg > astc_pkg::MAX_BLOCK) ? astc_pkg::MAX_BLOCK : blk_len_reg;
    endfunction

    function automatic int unsigned eff_cap();
        return (cap_len_reg < 1) ? 1 :
               (cap_len_reg > astc_pkg::CAPTURE_DEPTH) ? astc_pkg::CAPTURE_DEPTH : cap_len_reg;
    endfunction

    function automatic void note_total(int m);
        if (m < tot_lo) tot_lo = m;
        if (m > tot_hi) tot_hi = m;
    endfunction

    function automatic void store_capture(int m);
        if (cap_fill >= eff_cap()) begin
            if (wrap_mode) begin
                cap_fill  = 0;
                avail_cnt = eff_cap();
            end
            else begin
                mode = astc_pkg::MODE_IDLE;
                return;
            end
        end
        cap_mem[cap_fill]  = m;
        cap_seen[cap_fill] = 1;
        cap_fill++;
        avail_cnt++;
        if (avail_cnt > eff_cap()) avail_cnt = eff_cap();
        note_total(m);
    endfunction

    // Move the window trig_mem[from .. whole-1], cut to the capture length, into the capture store.
    function automatic void copy_window(int unsigned from, int unsigned whole);
        int unsigned n;
        n = whole - from;
        if (n > eff_cap()) n = eff_cap();
        for (int unsigned j = 0; j < n; j++) begin
            cap_mem[j]  = trig_mem[from + j];
            cap_seen[j] = 1;
            note_total(trig_mem[from + j]);
        end
        cap_fill  = n;
        avail_cnt = n;
        trig_wr   = 0;
        mode      = astc_pkg::MODE_CAPTURE;
    endfunction

    function automatic void search_edge(int unsigned b);
        int unsigned half;
        int          thr, s0, s1, s2;
        bit          hit;
        half = b / 2;
        thr  = lvl_pct * 32768;
        if (lvl_pct <= 2) begin
            trig_pt = 0;
            copy_window(0, 2 * b);
            return;
        end
        for (int unsigned i = half; i < half + b; i++) begin
            s0 = trig_mem[i];
            s1 = trig_mem[i + 1];
            s2 = trig_mem[i + 2];
            if (rising) hit = (s0 * 100 >= thr) && (s1 >= s0) && (s2 >= s1);
            else        hit = (s0 * 100 <= -thr) && (s1 <= s0) && (s2 <= s1);
            if (hit) begin
                trig_pt = half;
                copy_window(i - half, 2 * b);
                return;
            end
        end
    endfunction

    // Advance the shadow by one transaction; return 1 when it yields a result.
    function automatic bit predict_capture(input astc_pkg::func_t f, input logic [15:0] l,
                                           input logic [15:0] r, input logic [15:0] a,
                                           output astc_pkg::result_t res);
        int unsigned b;
        int          sum, m;
        res = '0;
        case (f)
            astc_pkg::FUNC_START: begin start_pend = 1; return 0; end
            astc_pkg::FUNC_ABORT: begin abort_pend = 1; return 0; end
            astc_pkg::FUNC_READ: begin
                res.kind = 1'b1;
                if (a < eff_cap()) res.read_data = cap_mem[a];
                return 1;
            end
            default: ;
        endcase
        b = eff_blk();
        if (blk_pos == 0) begin
            if (abort_pend) begin
                mode       = astc_pkg::MODE_ABORTED;
                abort_pend = 0;
                start_pend = 0;
            end
            if (start_pend) begin
                start_pend = 0;
                mode       = arm_on_start ? astc_pkg::MODE_WAIT : astc_pkg::MODE_CAPTURE;
                cap_fill   = 0;
                avail_cnt  = 0;
                trig_pt    = 0;
                trig_wr    = 0;
                tot_lo     = 32767;
                tot_hi     = -32768;
            end
            // keep only the newest block of a full trigger store
            if (mode == astc_pkg::MODE_WAIT && trig_wr >= 2 * b) begin
                for (int unsigned j = 0; j < b; j++) trig_mem[j] = trig_mem[trig_wr - b + j];
                trig_wr = b;
            end
        end
        sum = $signed(l) + $signed(r);
        m   = sum >>> 1;
        if (m < blk_lo) blk_lo = m;
        if (m > blk_hi) blk_hi = m;
        if (mode == astc_pkg::MODE_WAIT) begin
            if (trig_wr < 2 * b) trig_mem[trig_wr++] = m;
        end
        else if (mode == astc_pkg::MODE_CAPTURE) store_capture(m);
        blk_pos++;
        if (blk_pos < b) return 0;
        if (mode == astc_pkg::MODE_WAIT && trig_wr >= 2 * b) search_edge(b);
        res.block_min           = blk_lo;
        res.block_max           = blk_hi;
        res.total_min           = tot_lo;
        res.total_max           = tot_hi;
        res.status              = mode;
        res.samples_available   = avail_cnt;
        res.pretrigger_position = trig_pt;
        blk_pos = 0;
        blk_lo  = 32767;
        blk_hi  = -32768;
        return 1;
    endfunction

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Sink: stall at random unless quiet, compare each accepted result to the oldest expectation.
    initial
    begin
        astc_pkg::result_t exp_r, got;
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = '0;
                got.kind = m_tuser;
                {got.read_data, got.pretrigger_position, got.samples_available, got.status,
                 got.total_max, got.total_min, got.block_max, got.block_min} = m_tdata[108:0];
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result kind=%0d data=%h", $time, got.kind,
                             m_tdata);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (got.kind != exp_r.kind) begin errors++;
                        $display("%0t: kind exp %0d got %0d", $time, exp_r.kind, got.kind); end
                    if (got.block_min != exp_r.block_min) begin errors++;
                        $display("%0t: block_min exp %0d got %0d", $time, exp_r.block_min,
                                 got.block_min); end
                    if (got.block_max != exp_r.block_max) begin errors++;
                        $display("%0t: block_max exp %0d got %0d", $time, exp_r.block_max,
                                 got.block_max); end
                    if (got.total_min != exp_r.total_min) begin errors++;
                        $display("%0t: total_min exp %0d got %0d", $time, exp_r.total_min,
                                 got.total_min); end
                    if (got.total_max != exp_r.total_max) begin errors++;
                        $display("%0t: total_max exp %0d got %0d", $time, exp_r.total_max,
                                 got.total_max); end
                    if (got.status != exp_r.status) begin errors++;
                        $display("%0t: status exp %0d got %0d", $time, exp_r.status,
                                 got.status); end
                    if (got.samples_available != exp_r.samples_available) begin errors++;
                        $display("%0t: samples_available exp %0d got %0d", $time,
                                 exp_r.samples_available, got.samples_available); end
                    if (got.pretrigger_position != exp_r.pretrigger_position) begin errors++;
                        $display("%0t: pretrigger_position exp %0d got %0d", $time,
                                 exp_r.pretrigger_position, got.pretrigger_position); end
                    if (got.read_data != exp_r.read_data) begin errors++;
                        $display("%0t: read_data exp %0d got %0d", $time, exp_r.read_data,
                                 got.read_data); end
                end
            end
            m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 37);
        end
    end

    // Send one transaction; typed rows replace the predicted result with their own.
    task automatic send_item(input astc_pkg::func_t f, input logic [15:0] l,
                             input logic [15:0] r, input logic [15:0] a, input bit typed,
                             input astc_pkg::result_t typed_r);
        astc_pkg::result_t res;
        if (!quiet)
            while ($urandom_range(99) < 37)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {a, r, l};
        do @(posedge clk); while (!s_tready);
        if (predict_capture(f, l, r, a, res)) pending_results.push_back(typed ? typed_r : res);
    endtask

    // Drain, let any silent work finish, then write all six registers.
    task automatic set_registers(input int unsigned lvl, input int unsigned rise,
                                 input int unsigned arm, input int unsigned wrap,
                                 input int unsigned cap, input int unsigned blk);
        logic [16:0] vals [6];
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8 * astc_pkg::MAX_BLOCK + 200) @(posedge clk);
        vals = '{lvl, rise, arm, wrap, cap, blk};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= i;
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            case (astc_pkg::cfg_idx_t'(i))
                astc_pkg::CFG_LEVEL:    lvl_pct      = vals[i] & 7'h7F;
                astc_pkg::CFG_RISING:   rising       = vals[i] & 1;
                astc_pkg::CFG_ON_START: arm_on_start = vals[i] & 1;
                astc_pkg::CFG_CONTIG:   wrap_mode    = vals[i] & 1;
                astc_pkg::CFG_CAP_LEN:  cap_len_reg  = vals[i];
                default:                blk_len_reg  = vals[i] & 11'h7FF;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Pick a read address that never touches an unwritten entry.
    function automatic logic [15:0] pick_address();
        int unsigned a;
        a = $urandom_range(65535);
        if (a < eff_cap() && !cap_seen[a])
            a = (eff_cap() < astc_pkg::CAPTURE_DEPTH) ? $urandom_range(65535, eff_cap()) :
                $urandom_range(cap_fill == 0 ? 0 : cap_fill - 1);
        return a;
    endfunction

    typedef struct {
        astc_pkg::func_t   f;
        logic [15:0]       l, r, a;
        bit                typed;
        astc_pkg::result_t res;
    } stim_row_t;

    typedef struct {
        int unsigned lvl, rise, arm, wrap, cap, blk, items;
    } phase_t;

    initial
    begin
        stim_row_t         rows [20];
        phase_t            phases [8];
        astc_pkg::result_t none_r, rd_zero, first_rep;
        int                wave, step, amp, dir, n_items;
        logic [15:0]       l, r;
        int unsigned       pick;

        errors = 0;
        quiet = 0;
        rst_n = 0; s_tvalid = 0; s_tdata = '0; s_tuser = astc_pkg::FUNC_SAMPLE;
        cfg_valid = 0; cfg_index = astc_pkg::CFG_LEVEL; cfg_data = '0;
        trig_wr = 0; cap_fill = 0; avail_cnt = 0; blk_pos = 0; trig_pt = 0;
        blk_lo = 32767; blk_hi = -32768; tot_lo = 32767; tot_hi = -32768;
        mode = astc_pkg::MODE_IDLE; start_pend = 0; abort_pend = 0;
        lvl_pct = 0; rising = 1; arm_on_start = 0; wrap_mode = 0;
        cap_len_reg = 65536; blk_len_reg = 512;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: one-entry store, shortest block.
        set_registers(0, 1, 0, 0, 0, 4);
        none_r    = '0;
        rd_zero   = '0; rd_zero.kind = 1'b1;
        first_rep = '0;
        first_rep.block_min = astc_pkg::S16_MIN; first_rep.block_max = astc_pkg::S16_MAX;
        first_rep.total_min = astc_pkg::S16_MAX; first_rep.total_max = astc_pkg::S16_MIN;
        first_rep.status    = astc_pkg::MODE_IDLE;
        rows = '{
            '{astc_pkg::FUNC_READ,   16'h0000, 16'h0000, 16'hFFFF, 1, rd_zero}, // beyond store
            '{astc_pkg::FUNC_SAMPLE, 16'h8000, 16'h8000, 16'h0000, 0, none_r},
            '{astc_pkg::FUNC_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h0000, 0, none_r},
            '{astc_pkg::FUNC_SAMPLE, 16'hFFFF, 16'h0000, 16'h0000, 0, none_r}, // -1/2 rounds down
            '{astc_pkg::FUNC_SAMPLE, 16'h0000, 16'hFFFF, 16'h0000, 1, first_rep},
            '{astc_pkg::FUNC_START,  16'h0000, 16'h0000, 16'h0000, 0, none_r},
            '{astc_pkg::FUNC_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000, 0, none_r},
            '{astc_pkg::FUNC_SAMPLE, 16'h1234, 16'h4321, 16'h0000, 0, none_r}, // store full: idle
            '{astc_pkg::FUNC_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000, 0, none_r},
            '{astc_pkg::FUNC_SAMPLE, 16'h0001, 16'h0001, 16'h0000, 0, none_r},
            '{astc_pkg::FUNC_READ,   16'h0000, 16'h0000, 16'h0000, 0, none_r},
            '{astc_pkg::FUNC_READ,   16'h0000, 16'h0000, 16'h0001, 1, rd_zero},
            '{astc_pkg::FUNC_START,  16'h0000, 16'h0000, 16'h0000, 0, none_r},
            '{astc_pkg::FUNC_ABORT,  16'h0000, 16'h0000, 16'h0000, 0, none_r}, // abort wins
            '{astc_pkg::FUNC_SAMPLE, 16'h0100, 16'h0300, 16'h0000, 0, none_r},
            '{astc_pkg::FUNC_SAMPLE, 16'hFF00, 16'h0300, 16'h0000, 0, none_r},
            '{astc_pkg::FUNC_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 0, none_r},
            '{astc_pkg::FUNC_SAMPLE, 16'h5555, 16'hAAAA, 16'h0000, 0, none_r},
            '{astc_pkg::FUNC_READ,   16'h0000, 16'h0000, 16'h0000, 0, none_r},
            '{astc_pkg::FUNC_READ,   16'h0000, 16'h0000, 16'h8000, 1, rd_zero}
        };
        foreach (rows[i])
            send_item(rows[i].f, rows[i].l, rows[i].r, rows[i].a, rows[i].typed, rows[i].res);

        // Random phases: start, then mostly waveforms that cross the trigger level.
        phases = '{
            '{50,  1, 1, 0, 24,     8,    60},
            '{30,  0, 1, 1, 20,     6,    120},
            '{2,   1, 1, 1, 7,      4,    40},      // free run through the trigger store
            '{100, 0, 1, 0, 131071, 16,   60},
            '{127, 1, 1, 0, 40,     12,   40},      // level out of reach: never triggers
            '{3,   1, 1, 1, 65536,  10,   60},
            '{60,  1, 0, 0, 65535,  2047, 1040},    // largest block, direct capture
            '{1,   0, 1, 0, 1,      0,    40}
        };
        foreach (phases[p])
        begin
            set_registers(phases[p].lvl, phases[p].rise, phases[p].arm, phases[p].wrap,
                          phases[p].cap, phases[p].blk);
            quiet = (p == 5);
            send_item(astc_pkg::FUNC_START, '0, '0, '0, 0, none_r);
            amp  = $urandom_range(32767, 8000);
            step = $urandom_range(amp / 3 + 1, 200);
            wave = 0; dir = 1;
            n_items = phases[p].items;
            for (int k = 0; k < n_items; k++)
            begin
                if (p == 1 && k == 100)
                begin
                    s_tvalid <= 1'b0;
                    do @(posedge clk); while (pending_results.size() != 0);
                end
                pick = $urandom_range(99);
                if (pick < 2)
                    send_item(astc_pkg::FUNC_ABORT, '0, '0, '0, 0, none_r);
                else if (pick < 6)
                    send_item(astc_pkg::FUNC_START, '0, '0, '0, 0, none_r);
                else if (pick < 16)
                    send_item(astc_pkg::FUNC_READ, $urandom, $urandom, pick_address(), 0,
                              none_r);
                else if (pick < 30)
                    send_item(astc_pkg::FUNC_SAMPLE, $urandom, $urandom, $urandom, 0, none_r);
                else
                begin
                    wave += dir * step;
                    if (wave >= amp) begin wave = 32767; dir = -1; end
                    if (wave <= -amp) begin wave = -32768; dir = 1; end
                    l = wave;
                    r = (wave + $urandom_range(63)) > 32767 ? 32767 : wave + $urandom_range(63);
                    send_item(astc_pkg::FUNC_SAMPLE, l, r, $urandom, 0, none_r);
                end
            end
        end
        quiet = 0;
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (8 * astc_pkg::MAX_BLOCK + 200) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/astc_pkg.sv
hw/rtl/astc_ram.sv
hw/rtl/astc_front.sv
hw/rtl/astc_back.sv
hw/rtl/audio_scope_trigger_capture.sv
verif/tb_audio_scope_trigger_capture.sv
